### hw/rtl/timeout_timer_bank_core_defines.svh
// ----------------------------------------------------------------------------
// Timeout timer bank: assertion macros
// Shared property shorthands for the timer bank RTL.
// ----------------------------------------------------------------------------
`ifndef TIMEOUT_TIMER_BANK_CORE_DEFINES_SVH
`define TIMEOUT_TIMER_BANK_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TTB_ASSERT_IMP(lbl, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TTB_ASSERT_NXT(lbl, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ttb_pkg.sv
// ----------------------------------------------------------------------------
// Timeout timer bank: package
// Field widths, opcodes, FSM states and the structs between blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package ttb_pkg;

    localparam int OP_W   = 3;
    localparam int ID_W   = 5;
    localparam int DL_W   = 32;
    localparam int CNT_W  = 42;
    localparam int MASK_W = 32;
    localparam int PER_W  = 10;
    localparam int CO_W   = 10;
    // widest timer index (bank of up to 256 timers)
    localparam int IDX_W  = 8;
    // divider walks one quotient bit per cycle
    localparam int DIV_STEP_W = 4;

    localparam logic [PER_W-1:0] US_PER_MS  = 10'd1000;
    localparam logic [CO_W-1:0]  CO_RESET   = 10'd1;
    localparam logic [DIV_STEP_W-1:0] DIV_LAST_STEP = 4'd9;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_START   = 3'd1,
        OP_RESTART = 3'd2,
        OP_STOP    = 3'd3,
        OP_READ    = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SWEEP,
        ST_DRAIN,
        ST_READ,
        ST_RESP
    } t_state;

    // one sweep slot entering the update pipe
    typedef struct packed {
        logic             vld;
        logic             run;
        logic [IDX_W-1:0] idx;
    } t_swp;

    // count write-back from the update pipe
    typedef struct packed {
        logic             we;
        logic             exp;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] count;
    } t_wr;

endpackage

`default_nettype wire

### hw/rtl/ttb_ram.sv
// ----------------------------------------------------------------------------
// Timeout timer bank: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/ttb_div.sv
// ----------------------------------------------------------------------------
// Timeout timer bank: tick-rate divider
// Restoring divider, one bit per cycle, giving floor(1000 / tick period).
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_div
    import ttb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [PER_W-1:0] i_period,
    output logic                  o_busy,
    output logic                  o_tick_en,
    output logic      [CO_W-1:0]  o_co
);

    logic                  r_busy;
    logic [DIV_STEP_W-1:0] r_bit;
    logic [PER_W-1:0]      r_per;
    logic [PER_W-1:0]      r_rem;
    logic [CO_W-1:0]       r_q;
    logic [CO_W-1:0]       r_co;
    logic                  r_en;

    logic [PER_W:0]        w_trial;
    logic                  w_ge;
    logic [PER_W-1:0]      n_rem;
    logic [CO_W-1:0]       n_q;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        w_trial = {r_rem, US_PER_MS[r_bit]};
        w_ge    = (w_trial >= {1'b0, r_per});
        n_rem   = w_ge ? PER_W'(w_trial - {1'b0, r_per}) : w_trial[PER_W-1:0];
        n_q     = {r_q[CO_W-2:0], w_ge};
    end

    // control: busy flag, tick enable, quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_en   <= 1'b1;
            r_co   <= CO_RESET;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_en   <= (i_period != '0) && (i_period <= US_PER_MS);
        end else if (r_busy && (r_bit == '0)) begin
            r_busy <= 1'b0;
            r_co   <= n_q;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_per <= i_period;
            r_rem <= '0;
            r_q   <= '0;
            r_bit <= DIV_LAST_STEP;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            r_bit <= r_bit - 1'b1;
        end
    end

    assign o_busy    = r_busy;
    assign o_tick_en = r_en;
    assign o_co      = r_co;

endmodule

`default_nettype wire

### hw/rtl/ttb_upd.sv
// ----------------------------------------------------------------------------
// Timeout timer bank: tick update pipe
// Limit multiply, then count increment and compare with write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_upd
    import ttb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_swp             i_swp,
    input  wire logic [CO_W-1:0]  i_co,
    input  wire logic [CNT_W-1:0] i_cnt,
    input  wire logic [DL_W-1:0]  i_dl,
    output t_wr                   o_wr,
    output logic                  o_busy
);

    t_swp             r_s1;
    t_swp             r_s2;
    logic [CNT_W-1:0] r_cnt2;
    logic [CNT_W-1:0] r_lim2;

    logic [CNT_W-1:0] w_prod;
    logic [CNT_W:0]   w_next;
    logic             w_hit;

    // stage 1 lines up with the RAM read data; only the valid bits are reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
        end else begin
            r_s1.vld <= i_swp.vld;
            r_s2.vld <= r_s1.vld;
        end
        r_s1.run <= i_swp.run;
        r_s1.idx <= i_swp.idx;
        r_s2.run <= r_s1.run;
        r_s2.idx <= r_s1.idx;
        r_cnt2   <= i_cnt;
        r_lim2   <= w_prod;
    end

    // limit = deadline * ticks per ms (32 x 10 bits, fits the count width)
    assign w_prod = CNT_W'(i_dl) * CNT_W'(i_co);

    // stage 2: step the count, hold at the limit
    always_comb begin
        w_next      = {1'b0, r_cnt2} + 1'b1;
        w_hit       = (w_next >= {1'b0, r_lim2});
        o_wr.we     = r_s2.vld && r_s2.run;
        o_wr.exp    = w_hit;
        o_wr.idx    = r_s2.idx;
        o_wr.count  = w_hit ? r_lim2 : w_next[CNT_W-1:0];
    end

    assign o_busy = r_s1.vld || r_s2.vld;

endmodule

`default_nettype wire

### hw/rtl/timeout_timer_bank_core.sv
// ----------------------------------------------------------------------------
// Timeout timer bank: top level
// Bank of timeout timers stepped by tick requests, one request at a time.
// ----------------------------------------------------------------------------
// Request channel (i_valid / o_stall): opcode, timer id, deadline; tick,
//   start, restart, stop or read status. One response per request.
// Response channel (o_valid / i_stall): expired mask of timers 0..31, plus
//   running flag, expired flag and tick count of the addressed timer, all
//   as they stand after the request.
// Config channel (i_cfg_valid / o_cfg_ready): tick period in microseconds.
//   A write starts a divide for floor(1000 / period); requests are
//   stalled until it ends. Write it only while no request is in flight.
// Sweep: a tick, when the period lets ticks count, walks the timers one per
//   cycle through the count and deadline RAMs and a shared multiply/compare
//   pipe, then drains the pipe before the response; other requests skip the
//   sweep. The next request is accepted only after the response loads.
// Reset: timers stopped, period 1000 us; running flags act as RAM valid bits.
// Stall: a held response keeps its payload; the next request queues behind it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "timeout_timer_bank_core_defines.svh"

module timeout_timer_bank_core
    import ttb_pkg::*;
#(
    parameter int NUM_TIMERS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [ID_W-1:0]   i_timer_id,
    input  wire logic [DL_W-1:0]   i_deadline_ms,
    // response channel
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [MASK_W-1:0] o_expired_mask,
    output logic                   o_timer_running,
    output logic                   o_timer_expired,
    output logic      [CNT_W-1:0]  o_timer_count,
    // config channel
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [PER_W-1:0]  i_cfg_tick_period_us
);

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TIMERS - 1);

    t_state                r_state;
    t_state                n_state;
    logic [OP_W-1:0]       r_op;
    logic [ID_W-1:0]       r_id;
    logic [DL_W-1:0]       r_dl;
    logic [AW-1:0]         r_idx;
    logic [NUM_TIMERS-1:0] r_run;
    logic [NUM_TIMERS-1:0] r_exp;

    logic                  r_o_valid;
    logic [MASK_W-1:0]     r_o_mask;
    logic                  r_o_run;
    logic                  r_o_exp;
    logic [CNT_W-1:0]      r_o_cnt;

    logic                  w_accept;
    logic                  w_apply;
    logic                  w_sweep;
    logic                  w_read;
    logic                  w_load;
    logic [IDX_W-1:0]      w_id_ext;
    logic [AW-1:0]         w_id_addr;
    logic                  w_id_ok;
    logic                  w_do_start;
    logic                  w_do_restart;
    logic                  w_do_stop;
    logic [MASK_W-1:0]     w_mask;

    logic                  w_div_busy;
    logic                  w_tick_en;
    logic [CO_W-1:0]       w_co;

    t_swp                  w_swp;
    t_wr                   w_wr;
    logic                  w_upd_busy;

    logic                  w_cnt_we;
    logic [AW-1:0]         w_cnt_waddr;
    logic [CNT_W-1:0]      w_cnt_wdata;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;
    logic [CNT_W-1:0]      w_cnt_rdata;
    logic [DL_W-1:0]       w_dl_rdata;

    // handshakes
    assign o_stall     = (r_state != ST_IDLE) || w_div_busy;
    assign o_cfg_ready = !w_div_busy;
    assign w_accept    = i_valid && !o_stall;

    // addressed timer
    assign w_id_ext  = IDX_W'(r_id);
    assign w_id_addr = w_id_ext[AW-1:0];
    assign w_id_ok   = ({1'b0, w_id_ext} < (IDX_W + 1)'(NUM_TIMERS));

    // FSM: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if ((r_op == OP_TICK) && w_tick_en) begin
                    n_state = ST_SWEEP;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_SWEEP: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_upd_busy) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_RESP;
            ST_RESP: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // FSM: outputs
    always_comb begin
        w_apply = 1'b0;
        w_sweep = 1'b0;
        w_read  = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            ST_APPLY: w_apply = 1'b1;
            ST_SWEEP: w_sweep = 1'b1;
            ST_READ:  w_read  = 1'b1;
            ST_RESP:  w_load  = !r_o_valid || !i_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_opcode;
            r_id <= i_timer_id;
            r_dl <= i_deadline_ms;
        end
    end

    // single-timer operations
    assign w_do_start   = w_apply && w_id_ok && (r_op == OP_START);
    assign w_do_restart = w_apply && w_id_ok && (r_op == OP_RESTART);
    assign w_do_stop    = w_apply && w_id_ok && (r_op == OP_STOP);

    // sweep index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_apply) begin
            r_idx <= '0;
        end else if (w_sweep) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // running flags double as RAM valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (w_do_start) begin
            r_run[w_id_addr] <= 1'b1;
        end else if (w_do_stop) begin
            r_run[w_id_addr] <= 1'b0;
        end
    end

    // expired flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
        end else if (w_wr.we) begin
            r_exp[w_wr.idx[AW-1:0]] <= w_wr.exp;
        end else if (w_do_start || w_do_restart || w_do_stop) begin
            r_exp[w_id_addr] <= 1'b0;
        end
    end

    // tick period divider
    ttb_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cfg_valid && o_cfg_ready),
        .i_period  (i_cfg_tick_period_us),
        .o_busy    (w_div_busy),
        .o_tick_en (w_tick_en),
        .o_co      (w_co)
    );

    // sweep slot into the update pipe
    always_comb begin
        w_swp.vld = w_sweep;
        w_swp.run = r_run[r_idx];
        w_swp.idx = IDX_W'(r_idx);
    end

    ttb_upd u_upd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_swp   (w_swp),
        .i_co    (w_co),
        .i_cnt   (w_cnt_rdata),
        .i_dl    (w_dl_rdata),
        .o_wr    (w_wr),
        .o_busy  (w_upd_busy)
    );

    // RAM port muxing: sweep write-back or single-timer write
    assign w_cnt_we    = w_wr.we || w_do_start || w_do_restart;
    assign w_cnt_waddr = w_wr.we ? w_wr.idx[AW-1:0] : w_id_addr;
    assign w_cnt_wdata = w_wr.we ? w_wr.count : '0;
    assign w_re        = w_sweep || w_read;
    assign w_raddr     = w_sweep ? r_idx : w_id_addr;

    ttb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_TIMERS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_cnt_rdata)
    );

    ttb_ram #(
        .WIDTH (DL_W),
        .DEPTH (NUM_TIMERS)
    ) u_dl_ram (
        .i_clk   (i_clk),
        .i_we    (w_do_start),
        .i_waddr (w_id_addr),
        .i_wdata (r_dl),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_dl_rdata)
    );

    // expired mask over the first 32 timers
    for (genvar gi = 0; gi < MASK_W; gi++) begin : g_mask
        if (gi < NUM_TIMERS) begin : g_bit
            assign w_mask[gi] = r_exp[gi];
        end else begin : g_zero
            assign w_mask[gi] = 1'b0;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_mask <= w_mask;
            r_o_run  <= w_id_ok && r_run[w_id_addr];
            r_o_exp  <= w_id_ok && r_exp[w_id_addr];
            r_o_cnt  <= (w_id_ok && r_run[w_id_addr]) ? w_cnt_rdata : '0;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_expired_mask  = r_o_mask;
    assign o_timer_running = r_o_run;
    assign o_timer_expired = r_o_exp;
    assign o_timer_count   = r_o_cnt;

    // checks
    `TTB_ASSERT_IMP(a_exp_only_running, i_rst_n, 1'b1, ((r_exp & ~r_run) == '0),
                    "expired flag on a stopped timer")
    `TTB_ASSERT_IMP(a_wb_in_sweep, i_rst_n, w_wr.we,
                    ((r_state == ST_SWEEP) || (r_state == ST_DRAIN)),
                    "count write-back outside a tick sweep")
    `TTB_ASSERT_NXT(a_sweep_from_zero, i_rst_n, (w_apply && (r_op == OP_TICK) && w_tick_en),
                    ((r_state == ST_SWEEP) && (r_idx == '0)),
                    "tick sweep did not start at timer zero")
    `TTB_ASSERT_NXT(a_cfg_blocks_req, i_rst_n, (i_cfg_valid && o_cfg_ready), o_stall,
                    "request taken during period divide")

endmodule

`default_nettype wire

### dv/timeout_timer_bank_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timeout timer bank: self-checking testbench
// Sends tick, start, restart, stop, read and undefined requests through the
// request channel and checks every response against a predictor of the 32
// timers. The tick period is reprogrammed between phases, among them periods
// that make ticks count, periods that make ticks be ignored, and the extremes.
// Random gaps on both channels and long response hold-offs fill the block.
// ----------------------------------------------------------------------------
module timeout_timer_bank_core_test;
    import ttb_pkg::*;

    localparam int NUM_TIMERS       = 32;
    localparam int RESET_CYCLES     = 6;
    localparam int NUM_PHASES       = 9;
    localparam int REQS_PER_PHASE   = 148;
    localparam int QUIET_CYCLES     = 8;
    localparam int DRAIN_CYCLES     = 60;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int MAX_REPORTS      = 10;
    localparam int HOLD_LEN         = 500;
    localparam int HOLD_AT_A        = 4000;
    localparam int HOLD_AT_B        = 15000;
    localparam int HOLD_AT_C        = 30000;

    // opcodes outside the defined set read status only
    localparam logic [OP_W-1:0]  OP_UNDEF_LO = 3'd5;
    localparam logic [OP_W-1:0]  OP_UNDEF_HI = 3'd7;
    localparam logic [PER_W-1:0] PERIOD_MAX  = 10'd1023;
    localparam logic [DL_W-1:0]  DL_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] deadline;
    } t_req;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              running;
        logic              expired;
        logic [CNT_W-1:0]  count;
    } t_status;

    // DUT signals
    logic              i_clk;
    logic              i_rst_n              = 1'b0;
    logic              i_valid              = 1'b0;
    logic              o_stall;
    logic [OP_W-1:0]   i_opcode             = '0;
    logic [ID_W-1:0]   i_timer_id           = '0;
    logic [DL_W-1:0]   i_deadline_ms        = '0;
    logic              o_valid;
    logic              i_stall              = 1'b0;
    logic [MASK_W-1:0] o_expired_mask;
    logic              o_timer_running;
    logic              o_timer_expired;
    logic [CNT_W-1:0]  o_timer_count;
    logic              i_cfg_valid          = 1'b0;
    logic              o_cfg_ready;
    logic [PER_W-1:0]  i_cfg_tick_period_us = '0;

    // predicted timer state
    logic [CNT_W-1:0]  tmr_count    [NUM_TIMERS];
    logic [DL_W-1:0]   tmr_deadline [NUM_TIMERS];
    logic              tmr_running  [NUM_TIMERS];
    logic              tmr_expired  [NUM_TIMERS];
    logic [PER_W-1:0]  tick_period;

    t_req              request_q[$];
    t_status           expected_status_q[$];
    t_req              cur_req;
    t_status           predicted;
    t_status           want;
    t_status           got;

    bit                idle_en      = 1'b1;
    int unsigned       gap_left;
    int unsigned       stall_left;
    int unsigned       hold_left;
    int unsigned       cycle_cnt;
    int unsigned       quiet_cnt;
    int unsigned       error_cnt    = 0;

    timeout_timer_bank_core #(
        .NUM_TIMERS(NUM_TIMERS)
    ) uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_opcode             (i_opcode),
        .i_timer_id           (i_timer_id),
        .i_deadline_ms        (i_deadline_ms),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_expired_mask       (o_expired_mask),
        .o_timer_running      (o_timer_running),
        .o_timer_expired      (o_timer_expired),
        .o_timer_count        (o_timer_count),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_tick_period_us (i_cfg_tick_period_us)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // apply one request to the timer state, return the status it reports
    function automatic t_status step_timers(input t_req rq);
        t_status         st;
        logic [CO_W-1:0] co;
        logic [63:0]     lim;
        logic [CNT_W:0]  nxt;
        int              t;
        st = '0;
        if (rq.op == OP_TICK) begin
            // periods of zero or above one millisecond leave the timers alone
            if (tick_period != '0 && tick_period <= US_PER_MS) begin
                co = US_PER_MS / tick_period;
                for (t = 0; t < NUM_TIMERS; t++) begin
                    if (tmr_running[t]) begin
                        lim = 64'(tmr_deadline[t]) * 64'(co);
                        nxt = {1'b0, tmr_count[t]} + 1'b1;
                        if (64'(nxt) >= lim) begin
                            tmr_expired[t] = 1'b1;
                            tmr_count[t]   = lim[CNT_W-1:0];
                        end else begin
                            tmr_expired[t] = 1'b0;
                            tmr_count[t]   = nxt[CNT_W-1:0];
                        end
                    end
                end
            end
        end else if (rq.op == OP_START) begin
            tmr_count[rq.id]    = '0;
            tmr_deadline[rq.id] = rq.deadline;
            tmr_running[rq.id]  = 1'b1;
            tmr_expired[rq.id]  = 1'b0;
        end else if (rq.op == OP_RESTART) begin
            tmr_count[rq.id]   = '0;
            tmr_expired[rq.id] = 1'b0;
        end else if (rq.op == OP_STOP) begin
            tmr_count[rq.id]    = '0;
            tmr_deadline[rq.id] = '0;
            tmr_running[rq.id]  = 1'b0;
            tmr_expired[rq.id]  = 1'b0;
        end
        for (t = 0; t < NUM_TIMERS; t++)
            st.mask[t] = tmr_expired[t];
        st.running = tmr_running[rq.id];
        st.expired = tmr_expired[rq.id];
        st.count   = tmr_count[rq.id];
        return st;
    endfunction

    task automatic queue_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                 input logic [DL_W-1:0] dl);
        request_q.push_back({op, id, dl});
    endtask

    // block is idle once nothing is queued, offered or outstanding
    task automatic wait_quiet();
        while (request_q.size() != 0 || i_valid || expected_status_q.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // request driver: predicts on accept, then offers the next queued request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                predicted = step_timers(cur_req);
                expected_status_q.push_back(predicted);
            end
            if (i_valid && o_stall) begin
                // hold the stalled request
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (request_q.size() != 0) begin
                cur_req       = request_q.pop_front();
                i_opcode      <= cur_req.op;
                i_timer_id    <= cur_req.id;
                i_deadline_ms <= cur_req.deadline;
                i_valid       <= 1'b1;
                gap_left      <= idle_en ? pick_gap() : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-offs at fixed points of the run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycle_cnt <= 0;
            hold_left <= 0;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            if (cycle_cnt == HOLD_AT_A || cycle_cnt == HOLD_AT_B || cycle_cnt == HOLD_AT_C)
                hold_left <= HOLD_LEN;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    // response monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_expired_mask, o_timer_running, o_timer_expired, o_timer_count};
                if (expected_status_q.size() == 0) begin
                    if (error_cnt < MAX_REPORTS)
                        $display("[%0t] response with no request outstanding", $realtime);
                    error_cnt++;
                end else begin
                    want = expected_status_q.pop_front();
                    if (got != want) begin
                        if (error_cnt < MAX_REPORTS)
                            $display("[%0t] exp/got mask %h/%h run %b/%b expd %b/%b cnt %0d/%0d",
                                     $realtime, want.mask, got.mask, want.running,
                                     got.running, want.expired, got.expired,
                                     want.count, got.count);
                        error_cnt++;
                    end
                end
            end
            if (hold_left != 0) begin
                i_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_stall    <= 1'b1;
            end else begin
                i_stall    <= 1'b0;
                stall_left <= idle_en ? pick_gap() : 0;
            end
        end
    end

    // watchdog: no handshake on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt == WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no progress", $realtime);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    // stimulus and end of run
    initial begin
        t_req             rq;
        int unsigned      r;
        int               t;
        int               phase;
        int               n;
        logic [PER_W-1:0] period_val;

        for (t = 0; t < NUM_TIMERS; t++) begin
            tmr_count[t]    = '0;
            tmr_deadline[t] = '0;
            tmr_running[t]  = 1'b0;
            tmr_expired[t]  = 1'b0;
        end
        tick_period = US_PER_MS;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests, reset period of one millisecond
        queue_request(OP_READ,    5'd0,  '0);
        queue_request(OP_START,   5'd0,  '0);       // zero deadline: first tick expires
        queue_request(OP_TICK,    5'd0,  '0);
        queue_request(OP_START,   5'd31, DL_MAX);
        queue_request(OP_START,   5'd1,  32'd2);
        queue_request(OP_TICK,    5'd1,  '0);
        queue_request(OP_TICK,    5'd1,  DL_MAX);   // reaches its limit
        queue_request(OP_TICK,    5'd1,  '0);       // count holds at the limit
        queue_request(OP_RESTART, 5'd1,  '0);
        queue_request(OP_TICK,    5'd1,  '0);
        queue_request(OP_STOP,    5'd1,  '0);
        queue_request(OP_TICK,    5'd31, '0);
        queue_request(OP_READ,    5'd31, DL_MAX);
        queue_request(OP_UNDEF_LO,         5'd0,  '0);
        queue_request(OP_UNDEF_LO + 3'd1,  5'd21, 32'h5A5A_A5A5);
        queue_request(OP_UNDEF_HI,         5'd31, DL_MAX);
        queue_request(OP_RESTART, 5'd2,  '0);       // restart of a stopped timer
        queue_request(OP_TICK,    5'd2,  '0);
        queue_request(OP_STOP,    5'd31, '0);
        queue_request(OP_STOP,    5'd0,  '0);
        queue_request(OP_START,   5'd10, 32'd1);
        queue_request(OP_TICK,    5'd10, '0);
        queue_request(OP_READ,    5'd10, '0);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0) begin
                wait_quiet();
                case (phase)
                    1:       period_val = 10'd1;
                    2:       period_val = '0;
                    3:       period_val = 10'd500;
                    4:       period_val = PERIOD_MAX;
                    5:       period_val = 10'd333;
                    6:       period_val = US_PER_MS + 1'b1;
                    7:       period_val = US_PER_MS - 1'b1;
                    default: period_val = US_PER_MS;
                endcase
                // period write while the bank is idle
                @(posedge i_clk);
                i_cfg_valid          <= 1'b1;
                i_cfg_tick_period_us <= period_val;
                do @(posedge i_clk); while (!o_cfg_ready);
                i_cfg_valid <= 1'b0;
                tick_period = period_val;
            end
            idle_en = (phase % 3) != 2;

            // random mix, leaning on ticks and a few low timer ids
            for (n = 0; n < REQS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 45)      rq.op = OP_TICK;
                else if (r < 62) rq.op = OP_START;
                else if (r < 70) rq.op = OP_RESTART;
                else if (r < 78) rq.op = OP_STOP;
                else if (r < 90) rq.op = OP_READ;
                else             rq.op = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
                rq.id = ($urandom_range(0, 1) == 0) ? ID_W'($urandom_range(0, 7))
                                                    : ID_W'($urandom_range(0, NUM_TIMERS - 1));
                r = $urandom_range(0, 9);
                if (r < 7)      rq.deadline = $urandom_range(0, 6);
                else if (r < 9) rq.deadline = $urandom_range(0, 300);
                else            rq.deadline = $urandom;
                request_q.push_back(rq);
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_cnt == 0 && expected_status_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ttb_pkg.sv
hw/rtl/ttb_ram.sv
hw/rtl/ttb_div.sv
hw/rtl/ttb_upd.sv
hw/rtl/timeout_timer_bank_core.sv
dv/timeout_timer_bank_core_test.sv
